// ===== hw/rtl/nnrs_pkg.sv =====
// ----------------------------------------------------------------------------
// nnrs_pkg
// Shared types and constants of the nearest-neighbour rectangle scaler.
// ----------------------------------------------------------------------------
package nnrs_pkg;

	localparam int MaxWidth  = 512;
	localparam int MaxHeight = 512;
	localparam int XW = $clog2(MaxWidth);
	localparam int YW = $clog2(MaxHeight);
	localparam int SW = 10;    // size register width
	localparam int CW = 9;     // corner register width
	localparam int PW = 9;     // position field width
	localparam int DW = 10;    // config data width
	localparam int QW = PW + SW;   // dividend width
	localparam int RW = 3;     // config index width

	typedef enum logic [RW-1:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_AX     = 3'd2,
		REG_AY     = 3'd3,
		REG_BX     = 3'd4,
		REG_BY     = 3'd5
	} reg_idx_t;

	typedef enum logic {
		CMD_LOAD    = 1'b0,
		CMD_PROCESS = 1'b1
	} cmd_t;

	typedef struct packed {
		logic         command;
		logic [PW-1:0] pos_x;
		logic [PW-1:0] pos_y;
		logic [7:0]    red_in;
		logic [7:0]    green_in;
		logic [7:0]    blue_in;
	} in_item_t;

	typedef struct packed {
		logic [PW-1:0] out_x;
		logic [PW-1:0] out_y;
		logic [7:0]    red_out;
		logic [7:0]    green_out;
		logic [7:0]    blue_out;
		logic          replaced;
	} out_item_t;

	// one restoring-division step state
	typedef struct packed {
		logic [QW-1:0] num;
		logic [QW-1:0] rem;
		logic [CW-1:0] den;
	} div_t;

	function automatic div_t div_step(input div_t d);
		logic [QW:0] trial;
		div_t        r;
		trial = {d.rem, d.num[QW-1]};
		r     = d;
		r.num = {d.num[QW-2:0], 1'b0};
		if (trial >= {{(QW+1-CW){1'b0}}, d.den}) begin
			r.rem = QW'(trial - {{(QW+1-CW){1'b0}}, d.den});
			r.num[0] = 1'b1;
		end else begin
			r.rem = trial[QW-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/nearest_neighbor_rect_scaler.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_rect_scaler
// Source image store with a pipelined nearest-neighbour rectangle lookup.
// ----------------------------------------------------------------------------
// Takes one beat per clock when the output is not stalled. A process beat
// passes through a rectangle test stage, a 19-stage restoring divider with
// one quotient bit per stage, the image memory read and the output register;
// load beats produce nothing and write the image memory at the end of the
// pipe. The whole pipe advances together and freezes while the output is
// stalled. Loads and lookups reach the single memory port in order, so a read
// that follows a write to the same pixel sees the new value.
module nearest_neighbor_rect_scaler (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [nnrs_pkg::RW-1:0]   cfg_index,
	input  logic [nnrs_pkg::DW-1:0]   cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  nnrs_pkg::in_item_t        in_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output nnrs_pkg::out_item_t       out_item
);

	localparam int NSTG = nnrs_pkg::QW;
	localparam int XW = nnrs_pkg::XW;
	localparam int YW = nnrs_pkg::YW;
	localparam int CW = nnrs_pkg::CW;
	localparam int SW = nnrs_pkg::SW;
	localparam int QW = nnrs_pkg::QW;

	logic [SW-1:0] width_q, height_q;
	logic [CW-1:0] ax_q, ay_q, bx_q, by_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SW'(512);
			height_q <= SW'(512);
			ax_q <= '0; ay_q <= '0; bx_q <= '0; by_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nnrs_pkg::REG_WIDTH:  width_q  <= cfg_data;
				nnrs_pkg::REG_HEIGHT: height_q <= cfg_data;
				nnrs_pkg::REG_AX:     ax_q <= cfg_data[CW-1:0];
				nnrs_pkg::REG_AY:     ay_q <= cfg_data[CW-1:0];
				nnrs_pkg::REG_BX:     bx_q <= cfg_data[CW-1:0];
				nnrs_pkg::REG_BY:     by_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// effective sizes and ordered corners
	logic [SW-1:0] w_eff, h_eff;
	logic [CW-1:0] lx, hx, ly, hy;
	assign w_eff = (width_q  < SW'(nnrs_pkg::MaxWidth))  ? width_q  : SW'(nnrs_pkg::MaxWidth);
	assign h_eff = (height_q < SW'(nnrs_pkg::MaxHeight)) ? height_q : SW'(nnrs_pkg::MaxHeight);
	assign lx = (ax_q < bx_q) ? ax_q : bx_q;
	assign hx = (ax_q < bx_q) ? bx_q : ax_q;
	assign ly = (ay_q < by_q) ? ay_q : by_q;
	assign hy = (ay_q < by_q) ? by_q : ay_q;

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: rectangle test, dividend set-up
	logic              v_s1, ld_s1, hit_s1;
	nnrs_pkg::in_item_t it_s1;
	logic [QW-1:0]     nx_s1, ny_s1;
	logic [CW-1:0]     dx_s1, dy_s1;

	logic ok, inr, ldok;
	assign ok   = ({1'b0, hx} < w_eff) && ({1'b0, hy} < h_eff) && (hx > lx) && (hy > ly);
	assign inr  = (in_item.pos_x >= lx) && (in_item.pos_x < hx)
		&& (in_item.pos_y >= ly) && (in_item.pos_y < hy);
	assign ldok = ({1'b0, in_item.pos_x} < w_eff) && ({1'b0, in_item.pos_y} < h_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1  <= in_item;
			ld_s1  <= (in_item.command == nnrs_pkg::CMD_LOAD) && ldok;
			hit_s1 <= ok && inr;
			nx_s1  <= QW'(in_item.pos_x - lx) * QW'(w_eff);
			ny_s1  <= QW'(in_item.pos_y - ly) * QW'(h_eff);
			dx_s1  <= hx - lx;
			dy_s1  <= hy - ly;
		end
	end

	// divider stages: one quotient bit per stage on each axis
	logic               dv_q  [NSTG];
	logic               dld_q [NSTG];
	logic               dhit_q[NSTG];
	nnrs_pkg::in_item_t dit_q [NSTG];
	nnrs_pkg::div_t     dxs_q [NSTG];
	nnrs_pkg::div_t     dys_q [NSTG];
	nnrs_pkg::div_t     dx_in, dy_in;

	assign dx_in = '{num: nx_s1, rem: '0, den: dx_s1};
	assign dy_in = '{num: ny_s1, rem: '0, den: dy_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NSTG; k++) dv_q[k] <= 1'b0;
		end else if (adv) begin
			dv_q[0] <= v_s1;
			for (int k = 1; k < NSTG; k++) dv_q[k] <= dv_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dld_q[0]  <= ld_s1;
			dhit_q[0] <= hit_s1;
			dit_q[0]  <= it_s1;
			dxs_q[0]  <= nnrs_pkg::div_step(dx_in);
			dys_q[0]  <= nnrs_pkg::div_step(dy_in);
			for (int k = 1; k < NSTG; k++) begin
				dld_q[k]  <= dld_q[k-1];
				dhit_q[k] <= dhit_q[k-1];
				dit_q[k]  <= dit_q[k-1];
				dxs_q[k]  <= nnrs_pkg::div_step(dxs_q[k-1]);
				dys_q[k]  <= nnrs_pkg::div_step(dys_q[k-1]);
			end
		end
	end

	// memory stage: write loads, read for process beats
	logic               v_e, ld_e, hit_e;
	nnrs_pkg::in_item_t it_e;
	logic [QW-1:0]      sx, sy;
	logic               rd_ok;
	logic [XW+YW-1:0]   addr_e;
	assign v_e   = dv_q[NSTG-1];
	assign ld_e  = dld_q[NSTG-1];
	assign hit_e = dhit_q[NSTG-1];
	assign it_e  = dit_q[NSTG-1];
	assign sx    = dxs_q[NSTG-1].num;
	assign sy    = dys_q[NSTG-1].num;
	assign rd_ok = (sx < QW'(w_eff)) && (sy < QW'(h_eff));
	assign addr_e = (it_e.command == nnrs_pkg::CMD_LOAD)
		? {it_e.pos_y[YW-1:0], it_e.pos_x[XW-1:0]}
		: {sy[YW-1:0], sx[XW-1:0]};

	logic [23:0] img_mem [2**(XW+YW)];
	logic [23:0] rd_q;
	logic        v_s3, rep_s3;
	nnrs_pkg::in_item_t it_s3;

	// single port: one beat does either a write or a read
	always_ff @(posedge clk) begin
		if (adv && v_e) begin
			if (it_e.command == nnrs_pkg::CMD_LOAD) begin
				if (ld_e) img_mem[addr_e] <= {it_e.red_in, it_e.green_in, it_e.blue_in};
			end else begin
				rd_q <= img_mem[addr_e];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_e && (it_e.command == nnrs_pkg::CMD_PROCESS);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s3  <= it_e;
			rep_s3 <= hit_e && rd_ok;
		end
	end

	// output register; reads and writes are strictly ordered at one port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item.out_x    <= it_s3.pos_x;
			out_item.out_y    <= it_s3.pos_y;
			out_item.red_out   <= rep_s3 ? rd_q[23:16] : it_s3.red_in;
			out_item.green_out <= rep_s3 ? rd_q[15:8]  : it_s3.green_in;
			out_item.blue_out  <= rep_s3 ? rd_q[7:0]   : it_s3.blue_in;
			out_item.replaced  <= rep_s3;
		end
	end

	// checks
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("output beat changed while stalled");
	a_no_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled without a waiting output");
	a_adv_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |=> out_valid == $past(v_s3))
		else $error("output valid out of step with pipe");

endmodule
